// ===== rtl/ardm_pkg.sv =====
`default_nettype none

package ardm_pkg;

    localparam int FRAC_BITS = 8;

    localparam int MAG_W      = 20;
    localparam int FULL_SCALE = 256000;

    localparam int Q_FRAC    = 30;
    localparam int Q_W       = Q_FRAC + 1;
    localparam int DIV_STEPS = Q_W;

    localparam int F_W = Q_FRAC + 2;

    localparam int SCALE   = 100 << FRAC_BITS;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int PROD_W  = Q_W + SCALE_W;
    localparam int P_W     = PROD_W - Q_FRAC;
    localparam int POWER_W = 16;
    localparam int PX_W    = (P_W > POWER_W) ? P_W : POWER_W;
    localparam int PMAG_W  = POWER_W - 1;
    localparam int PMAX    = (1 << PMAG_W) - 1;

    localparam int DZ_W     = 7;
    localparam int RATING_W = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [DZ_W-1:0]     DZ_RESET     = 7'd5;
    localparam logic [RATING_W-1:0] RATING_RESET = 9'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE   = 2'd0,
        CFG_FWD_RATING  = 2'd1,
        CFG_TURN_RATING = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DZ_W-1:0]     dead_zone;
        logic [RATING_W-1:0] fwd_rating;
        logic [RATING_W-1:0] turn_rating;
    } t_cfg;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_side;

    typedef struct packed {
        t_side            left;
        t_side            right;
        logic [MAG_W-1:0] den;
    } t_norm;

    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] quo;
    } t_ratio;

endpackage

`default_nettype wire

// ===== rtl/ardm_mix.sv =====
`default_nettype none

module ardm_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ardm_pkg::t_cfg      i_cfg,
    input  logic                i_vld,
    input  logic signed [7:0]   i_fwd_now,
    input  logic signed [7:0]   i_fwd_prev,
    input  logic signed [7:0]   i_turn_now,
    input  logic signed [7:0]   i_turn_prev,
    output logic                o_vld,
    output ardm_pkg::t_norm     o_norm
);
    import ardm_pkg::*;

    typedef struct packed {
        logic [11:0] k_now;
        logic [11:0] k_prev;
    } t_coef;

    function automatic t_coef axis_coef(input logic [RATING_W-1:0] rating,
                                        input logic [DZ_W-1:0] dz,
                                        input logic signed [7:0] now);
        logic [RATING_W-1:0] rc;
        logic [7:0]          mag;
        logic [11:0]         five_r;
        t_coef               res;
        rc     = (rating > 9'd256) ? 9'd256 : rating;
        mag    = now[7] ? 8'(-now) : 8'(now);
        five_r = 12'({rc, 2'b00}) + 12'(rc);
        if (mag > {1'b0, dz}) begin
            res.k_now  = 12'd1024 + five_r;
            res.k_prev = 12'd1536 - five_r;
        end else begin
            res.k_now  = '0;
            res.k_prev = 12'd768 - 12'({rc, 1'b0});
        end
        return res;
    endfunction

    t_coef n_fc;
    t_coef n_tc;
    logic signed [20:0] n_fp1, n_fp2, n_tp1, n_tp2;
    logic signed [20:0] r_fp1, r_fp2, r_tp1, r_tp2;
    logic signed [21:0] n_sf, n_st, n_l, n_r;
    logic signed [21:0] r_l, r_r;
    logic [MAG_W-1:0]   n_al, n_ar, n_m;
    t_norm              n_norm;
    t_norm              r_norm;
    logic [2:0]         r_vld;

    always_comb begin
        n_fc  = axis_coef(i_cfg.fwd_rating, i_cfg.dead_zone, i_fwd_now);
        n_tc  = axis_coef(i_cfg.turn_rating, i_cfg.dead_zone, i_turn_now);
        n_fp1 = i_fwd_now   * $signed({1'b0, n_fc.k_now});
        n_fp2 = i_fwd_prev  * $signed({1'b0, n_fc.k_prev});
        n_tp1 = i_turn_now  * $signed({1'b0, n_tc.k_now});
        n_tp2 = i_turn_prev * $signed({1'b0, n_tc.k_prev});
    end

    always_comb begin
        n_sf = r_fp1 + r_fp2;
        n_st = r_tp1 + r_tp2;
        n_l  = n_sf + n_st;
        n_r  = n_sf - n_st;
    end

    always_comb begin
        n_al = MAG_W'(r_l[21] ? -r_l : r_l);
        n_ar = MAG_W'(r_r[21] ? -r_r : r_r);
        n_m  = (n_al > n_ar) ? n_al : n_ar;
        n_norm.left.neg  = r_l[21];
        n_norm.left.mag  = n_al;
        n_norm.right.neg = r_r[21];
        n_norm.right.mag = n_ar;
        n_norm.den       = (n_m > MAG_W'(FULL_SCALE)) ? n_m : MAG_W'(FULL_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fp1  <= n_fp1;
            r_fp2  <= n_fp2;
            r_tp1  <= n_tp1;
            r_tp2  <= n_tp2;
            r_l    <= n_l;
            r_r    <= n_r;
            r_norm <= n_norm;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_norm = r_norm;

endmodule

`default_nettype wire

// ===== rtl/ardm_div.sv =====
`default_nettype none

module ardm_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  ardm_pkg::t_norm  i_norm,
    output logic             o_vld,
    output ardm_pkg::t_ratio o_left,
    output ardm_pkg::t_ratio o_right
);
    import ardm_pkg::*;

    logic [DIV_STEPS-1:0] r_vld;
    logic [MAG_W-1:0]     r_den [DIV_STEPS];
    logic [MAG_W-1:0]     r_rem [2][DIV_STEPS];
    logic [Q_W-1:0]       r_quo [2][DIV_STEPS];
    logic                 r_neg [2][DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_norm.den;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_den[s] <= r_den[s-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
            logic [MAG_W:0]   n_trial;
            logic [MAG_W-1:0] n_den_in;
            logic [Q_W-1:0]   n_quo_in;
            logic             n_neg_in;
            logic             n_ge;

            if (s == 0) begin : g_first
                assign n_trial  = {1'b0, (l == 0) ? i_norm.left.mag : i_norm.right.mag};
                assign n_neg_in = (l == 0) ? i_norm.left.neg : i_norm.right.neg;
                assign n_den_in = i_norm.den;
                assign n_quo_in = '0;
            end else begin : g_next
                assign n_trial  = {r_rem[l][s-1], 1'b0};
                assign n_neg_in = r_neg[l][s-1];
                assign n_den_in = r_den[s-1];
                assign n_quo_in = r_quo[l][s-1];
            end

            assign n_ge = (n_trial >= {1'b0, n_den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][s] <= n_ge ? MAG_W'(n_trial - {1'b0, n_den_in})
                                        : n_trial[MAG_W-1:0];
                    r_quo[l][s] <= {n_quo_in[Q_W-2:0], n_ge};
                    r_neg[l][s] <= n_neg_in;
                end
            end
        end
    end

    assign o_vld        = r_vld[DIV_STEPS-1];
    assign o_left.neg   = r_neg[0][DIV_STEPS-1];
    assign o_left.quo   = r_quo[0][DIV_STEPS-1];
    assign o_right.neg  = r_neg[1][DIV_STEPS-1];
    assign o_right.quo  = r_quo[1][DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/ardm_shape.sv =====
`default_nettype none

module ardm_shape (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  ardm_pkg::t_ratio           i_left,
    input  ardm_pkg::t_ratio           i_right,
    output logic                       o_vld,
    output logic signed [ardm_pkg::POWER_W-1:0] o_left_power,
    output logic signed [ardm_pkg::POWER_W-1:0] o_right_power,
    output logic                       o_left_stopped,
    output logic                       o_right_stopped
);
    import ardm_pkg::*;

    localparam logic [F_W-1:0] THREE = F_W'(3) << Q_FRAC;

    t_ratio                    lane_in  [2];
    logic [Q_W-1:0]            r_x2     [2];
    logic [F_W-1:0]            r_f      [2];
    logic [Q_W-1:0]            r_y      [2];
    logic [PMAG_W-1:0]         r_p      [2];
    logic signed [POWER_W-1:0] r_power  [2];
    logic                      r_stop   [2];
    logic                      r_neg1   [2];
    logic                      r_neg2   [2];
    logic                      r_neg3   [2];
    logic [3:0]                r_vld;

    assign lane_in[0] = i_left;
    assign lane_in[1] = i_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [2*Q_W-1:0]         n_sq;
        logic [F_W-1:0]           n_f;
        logic [Q_W+F_W-1:0]       n_cube;
        logic [PROD_W-1:0]        n_scaled;
        logic [PX_W-1:0]          n_pext;
        logic [PMAG_W-1:0]        n_p;
        logic signed [POWER_W-1:0] n_power;

        always_comb begin
            n_sq     = lane_in[l].quo * lane_in[l].quo;
            n_f      = THREE - {lane_in[l].quo, 1'b0};
            n_cube   = r_x2[l] * r_f[l];
            n_scaled = r_y[l] * SCALE_W'(SCALE);
            n_pext   = PX_W'(n_scaled[PROD_W-1:Q_FRAC]);
            n_p      = (n_pext > PX_W'(PMAX)) ? PMAG_W'(PMAX) : n_pext[PMAG_W-1:0];
            n_power  = r_neg3[l] ? -$signed({1'b0, r_p[l]}) : $signed({1'b0, r_p[l]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x2[l]    <= n_sq[Q_FRAC +: Q_W];
                r_f[l]     <= n_f;
                r_neg1[l]  <= lane_in[l].neg;
                r_y[l]     <= n_cube[Q_FRAC +: Q_W];
                r_neg2[l]  <= r_neg1[l];
                r_p[l]     <= n_p;
                r_neg3[l]  <= r_neg2[l];
                r_power[l] <= n_power;
                r_stop[l]  <= (r_p[l] == '0);
            end
        end
    end

    assign o_vld           = r_vld[3];
    assign o_left_power    = r_power[0];
    assign o_right_power   = r_power[1];
    assign o_left_stopped  = r_stop[0];
    assign o_right_stopped = r_stop[1];

endmodule

`default_nettype wire

// ===== rtl/arcade_drive_mixer.sv =====
// Pipeline: 3 mix stages, 31 divider steps at one quotient bit per stage and 4
// shaping stages lie between request accept and result valid.
// Throughput: one request per cycle; a stalled result freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads dead_zone = 5
// and both ratings = 128; payload registers are not reset.
`default_nettype none

module arcade_drive_mixer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ardm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ardm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [7:0]                i_forward_now,
    input  logic signed [7:0]                i_forward_prev,
    input  logic signed [7:0]                i_turn_now,
    input  logic signed [7:0]                i_turn_prev,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [15:0]               o_left_power,
    output logic signed [15:0]               o_right_power,
    output logic                             o_left_stopped,
    output logic                             o_right_stopped
);
    import ardm_pkg::*;

    t_cfg   r_cfg;
    logic   en;
    logic   mix_vld;
    t_norm  mix_norm;
    logic   div_vld;
    t_ratio div_left;
    t_ratio div_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone   <= DZ_RESET;
            r_cfg.fwd_rating  <= RATING_RESET;
            r_cfg.turn_rating <= RATING_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEAD_ZONE:   r_cfg.dead_zone   <= i_cfg_data[DZ_W-1:0];
                CFG_FWD_RATING:  r_cfg.fwd_rating  <= i_cfg_data[RATING_W-1:0];
                CFG_TURN_RATING: r_cfg.turn_rating <= i_cfg_data[RATING_W-1:0];
                default: ;
            endcase
        end
    end

    // hold every stage while the result is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    ardm_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_cfg       (r_cfg),
        .i_vld       (i_valid),
        .i_fwd_now   (i_forward_now),
        .i_fwd_prev  (i_forward_prev),
        .i_turn_now  (i_turn_now),
        .i_turn_prev (i_turn_prev),
        .o_vld       (mix_vld),
        .o_norm      (mix_norm)
    );

    ardm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mix_vld),
        .i_norm  (mix_norm),
        .o_vld   (div_vld),
        .o_left  (div_left),
        .o_right (div_right)
    );

    ardm_shape u_shape (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (div_vld),
        .i_left          (div_left),
        .i_right         (div_right),
        .o_vld           (o_valid),
        .o_left_power    (o_left_power),
        .o_right_power   (o_right_power),
        .o_left_stopped  (o_left_stopped),
        .o_right_stopped (o_right_stopped)
    );

endmodule

`default_nettype wire
